[hdl/bpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpt_pkg: shared types and constants for the breakpoint table
// command and status codes, field widths and controller commands
// ----------------------------------------------------------------------------
package bpt_pkg;

   localparam int CMD_W    = 3;
   localparam int ADDR_W   = 48;
   localparam int WORD_W   = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 5;

   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ARM    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISARM = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // software trap opcode patched into the low byte of an armed word
   localparam logic [7:0] TRAP_BYTE = 8'hCC;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and compare against all entries
      logic execute;   // resolve, update table, load response
   } ctrl_cmd_type;

endpackage

[hdl/bpt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpt_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bpt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpt_ctrl: transaction controller
// two state sequencer: idle/capture, then execute; drives response strobe
// ----------------------------------------------------------------------------
module bpt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output bpt_pkg::ctrl_cmd_type cmd,
   output logic                  rsp_strobe
);
   import bpt_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = cmd.execute;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = strobe_ff;

endmodule

[hdl/bpt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpt_datapath: breakpoint entries, match logic and response registers
// per entry compare cells, valid marks, saved word ram
// ----------------------------------------------------------------------------
module bpt_datapath #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bpt_pkg::ctrl_cmd_type         cmd,
   input  logic [bpt_pkg::CMD_W-1:0]     req_command,
   input  logic [bpt_pkg::ADDR_W-1:0]    req_address,
   input  logic [bpt_pkg::WORD_W-1:0]    req_fetched_word,
   output logic [bpt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bpt_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [bpt_pkg::WORD_W-1:0]    rsp_out_word
);
   import bpt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // entry storage
   logic                 valid_ff   [TABLE_ENTRIES];
   logic                 written_ff [TABLE_ENTRIES];
   logic [ADDR_W-1:0]    entry_address_ff [TABLE_ENTRIES];

   // captured request
   logic [CMD_W-1:0]     cmd_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [WORD_W-1:0]    fetched_ff;
   logic [TABLE_ENTRIES-1:0] match_ff, match_in;
   logic [TABLE_ENTRIES-1:0] free_ff, free_in;

   // resolution
   logic [IDX_W-1:0]     hit_idx, free_idx;
   logic                 hit_any, free_any;
   logic [STATUS_W-1:0]  status_in;
   logic [SLOT_W-1:0]    slot_in;
   logic [WORD_W-1:0]    word_in;
   logic                 set_valid, clr_valid, arm_we, is_disarm;

   // response
   logic [STATUS_W-1:0]  status_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [WORD_W-1:0]    word_ff;
   logic                 disarm_ff;
   logic                 written_sel_ff;
   logic [WORD_W-1:0]    ram_q;

   always_comb begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         match_in[k] = valid_ff[k] && (entry_address_ff[k] == req_address);
         free_in[k]  = !valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff     <= req_command;
         addr_ff    <= req_address;
         fetched_ff <= req_fetched_word;
         match_ff   <= match_in;
         free_ff    <= free_in;
      end
   end

   // lowest set bit wins
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (match_ff[k]) begin
            hit_idx = IDX_W'(k);
         end
         if (free_ff[k]) begin
            free_idx = IDX_W'(k);
         end
      end
      hit_any  = |match_ff;
      free_any = |free_ff;
   end

   always_comb begin
      status_in = STATUS_NOT_FOUND;
      slot_in   = '0;
      word_in   = '0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      arm_we    = 1'b0;
      is_disarm = 1'b0;
      unique case (cmd_ff)
         CMD_ADD: begin
            if (hit_any) begin
               status_in = STATUS_PRESENT;
            end else if (free_any) begin
               status_in = STATUS_OK;
               slot_in   = SLOT_W'(free_idx);
               set_valid = 1'b1;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         CMD_REMOVE, CMD_FIND, CMD_ARM, CMD_DISARM: begin
            if (hit_any) begin
               status_in = STATUS_OK;
               slot_in   = SLOT_W'(hit_idx);
               clr_valid = (cmd_ff == CMD_REMOVE);
               arm_we    = (cmd_ff == CMD_ARM);
               is_disarm = (cmd_ff == CMD_DISARM);
               if (cmd_ff == CMD_ARM) begin
                  word_in = {fetched_ff[WORD_W-1:8], TRAP_BYTE};
               end
            end
         end
         default: begin
            status_in = STATUS_NOT_FOUND;
         end
      endcase
   end

   // valid marks and saved-word flags clear at reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (reset) begin
            valid_ff[k]   <= 1'b0;
            written_ff[k] <= 1'b0;
         end else if (cmd.execute) begin
            if (set_valid && (free_idx == IDX_W'(k))) begin
               valid_ff[k] <= 1'b1;
            end else if (clr_valid && (hit_idx == IDX_W'(k))) begin
               valid_ff[k] <= 1'b0;
            end
            if (arm_we && (hit_idx == IDX_W'(k))) begin
               written_ff[k] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (cmd.execute && set_valid && (free_idx == IDX_W'(k))) begin
            entry_address_ff[k] <= addr_ff;
         end
      end
   end

   bpt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_saved_word (
      .clock   (clock),
      .wr_en   (cmd.execute && arm_we),
      .wr_addr (hit_idx),
      .wr_data (fetched_ff),
      .rd_addr (hit_idx),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff      <= status_in;
         slot_ff        <= slot_in;
         word_ff        <= word_in;
         disarm_ff      <= is_disarm;
         written_sel_ff <= written_ff[hit_idx];
      end
   end

   assign rsp_status   = status_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_out_word = disarm_ff ? (written_sel_ff ? ram_q : '0) : word_ff;

endmodule

[hdl/breakpoint_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_table: fixed table of breakpoint addresses with saved words
// add, remove, find, arm and disarm over a small associative table
// ----------------------------------------------------------------------------
// flow: a transaction accepted while idle has the compare of all entries
//   registered, then the execute state resolves and updates the table; busy
//   is high only there and no new transaction is taken until idle again;
//   the result is then registered and shown with rsp_strobe
// reset: synchronous, clears all valid marks and saved-word flags with no
//   clearing pass
module breakpoint_table #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bpt_pkg::CMD_W-1:0]     req_command,
   input  logic [bpt_pkg::ADDR_W-1:0]    req_address,
   input  logic [bpt_pkg::WORD_W-1:0]    req_fetched_word,
   output logic                          rsp_strobe,
   output logic [bpt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bpt_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [bpt_pkg::WORD_W-1:0]    rsp_out_word
);
   import bpt_pkg::*;

   // command bundle from sequencer to datapath
   ctrl_cmd_type cmd;

   // sequencer: accepts a transaction when idle, then runs the execute state
   bpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // entries, compare cells, saved word storage and response registers
   bpt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_fetched_word (req_fetched_word),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_out_word     (rsp_out_word)
   );

endmodule

[hdl/bpt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpt_checker: port level checks for the breakpoint table
// timing of busy and strobe, and zero payload on error status
// ----------------------------------------------------------------------------
module bpt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [bpt_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bpt_pkg::SLOT_W-1:0]    rsp_slot,
   input logic [bpt_pkg::WORD_W-1:0]    rsp_out_word
);
   import bpt_pkg::*;

   // every accepted transaction is followed by a result strobe
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a preceding execute cycle");

   // busy lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // failed transactions carry zero slot and zero word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |->
         ((rsp_slot == '0) && (rsp_out_word == '0)))
      else $error("nonzero payload on error status");

endmodule

bind breakpoint_table bpt_checker u_bpt_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_slot     (rsp_slot),
   .rsp_out_word (rsp_out_word)
);
